/* hw/rtl/sfpd_pkg.sv */
// shared types and constants for the serial frame to pulse durations block
`default_nettype none
package sfpd_pkg;

    localparam int unsigned FRAME_CELLS  = 10;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PERIOD_W     = 13;
    localparam int unsigned DUR_W        = 16;
    localparam int unsigned POS_W        = 4;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 13'd1667;
    localparam logic [DUR_W-1:0]    DUR_MAX      = 16'hFFFF;

    typedef logic [FRAME_CELLS-1:0] t_mask;

    typedef struct packed {
        logic  valid;
        t_mask mask;
    } t_run_item;

endpackage
`default_nettype wire

/* hw/rtl/serial_frame_to_pulse_durations.sv */
// top level: frames bytes as 8n1 characters and emits run durations
// path: a byte passes the front register, the queue, then the back end's mask and output registers
// throughput: one run per cycle while pop keeps the output free; the back end has a single multiplier
// a byte yields as many runs as its frame has, 2 to 10
// reset: synchronous active low, clears queue and pipeline, bit period 1667
`default_nettype none
module serial_frame_to_pulse_durations #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [sfpd_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [sfpd_pkg::DUR_W-1:0]         o_run_duration,
    output logic                               o_last_run,
    input  wire logic                          i_cfg_we,
    input  wire logic [sfpd_pkg::PERIOD_W-1:0] i_cfg_wdata
);

    logic [sfpd_pkg::PERIOD_W-1:0] r_bit_period;
    sfpd_pkg::t_run_item           w_q_wr;
    sfpd_pkg::t_run_item           w_q_rd;
    logic                          w_q_full;
    logic                          w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= sfpd_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_bit_period <= i_cfg_wdata;
        end
    end

    sfpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_data_byte (i_data_byte),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr)
    );

    sfpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_q_wr),
        .o_full   (w_q_full),
        .o_rd     (w_q_rd),
        .i_rd_pop (w_q_pop)
    );

    sfpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bit_period   (r_bit_period),
        .i_rd           (w_q_rd),
        .o_rd_pop       (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_run_duration (o_run_duration),
        .o_last_run     (o_last_run)
    );

endmodule
`default_nettype wire

/* hw/rtl/sfpd_front.sv */
// front end: accepts bytes, frames them and marks run boundaries
`default_nettype none
module sfpd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic [sfpd_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_q_full,
    output sfpd_pkg::t_run_item                o_q_wr
);

    logic                r_valid;
    sfpd_pkg::t_mask     r_mask;
    logic                n_valid;
    sfpd_pkg::t_mask     n_mask;
    sfpd_pkg::t_mask     w_frame;
    sfpd_pkg::t_mask     w_ends;
    logic                w_accept;
    logic                w_write;

    // start bit low, data lsb first, stop bit high
    assign w_frame = {1'b1, i_data_byte, 1'b0};

    // bit i set where a run ends at cell i
    always_comb begin
        for (int i = 0; i < int'(sfpd_pkg::FRAME_CELLS) - 1; i++) begin
            w_ends[i] = w_frame[i] ^ w_frame[i+1];
        end
        w_ends[sfpd_pkg::FRAME_CELLS-1] = 1'b1;
    end

    assign w_write  = r_valid && !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;

    always_comb begin
        n_valid = r_valid;
        n_mask  = r_mask;
        if (w_accept) begin
            n_valid = 1'b1;
            n_mask  = w_ends;
        end else if (w_write) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_mask <= n_mask;
    end

    assign o_q_wr.valid = w_write;
    assign o_q_wr.mask  = r_mask;

endmodule
`default_nettype wire

/* hw/rtl/sfpd_queue.sv */
// short queue of boundary masks between front and back
`default_nettype none
module sfpd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sfpd_pkg::t_run_item i_wr,
    output logic                     o_full,
    output sfpd_pkg::t_run_item      o_rd,
    input  wire logic                i_rd_pop
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sfpd_pkg::t_mask r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full     = (r_count == FULL_CNT);
    assign o_rd.valid = (r_count != '0);
    assign o_rd.mask  = r_mem[r_rd_ptr];

    assign w_wr = i_wr.valid;
    assign w_rd = i_rd_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr.mask;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> !o_full)
        else $error("queue written while full");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd |-> o_rd.valid)
        else $error("queue read while empty");

endmodule
`default_nettype wire

/* hw/rtl/sfpd_back.sv */
// back end: walks run boundaries and scales each run by the bit period
`default_nettype none
module sfpd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sfpd_pkg::PERIOD_W-1:0] i_bit_period,
    input  wire sfpd_pkg::t_run_item           i_rd,
    output logic                               o_rd_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [sfpd_pkg::DUR_W-1:0]         o_run_duration,
    output logic                               o_last_run
);

    localparam int unsigned PROD_W = sfpd_pkg::PERIOD_W + sfpd_pkg::POS_W;
    localparam logic [sfpd_pkg::POS_W-1:0] LAST_POS =
        sfpd_pkg::POS_W'(sfpd_pkg::FRAME_CELLS - 1);

    sfpd_pkg::t_mask              r_mask;
    logic [sfpd_pkg::POS_W-1:0]   r_pos;
    logic                         r_out_valid;
    logic [sfpd_pkg::DUR_W-1:0]   r_dur;
    logic                         r_last;

    sfpd_pkg::t_mask              n_mask;
    logic [sfpd_pkg::POS_W-1:0]   n_pos;
    sfpd_pkg::t_mask              w_rest;
    logic [sfpd_pkg::POS_W-1:0]   w_idx;
    logic [sfpd_pkg::POS_W-1:0]   w_run;
    logic [PROD_W-1:0]            w_prod;
    logic                         w_busy;
    logic                         w_adv;
    logic                         w_take;

    assign w_busy = (r_mask != '0);
    assign w_adv  = !r_out_valid || i_pop;
    assign w_rest = r_mask & (r_mask - sfpd_pkg::t_mask'(1));

    // lowest pending run end
    always_comb begin
        w_idx = LAST_POS;
        for (int i = int'(sfpd_pkg::FRAME_CELLS) - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = sfpd_pkg::POS_W'(i);
            end
        end
    end

    assign w_run  = w_idx - r_pos + sfpd_pkg::POS_W'(1);
    assign w_prod = PROD_W'(w_run) * PROD_W'(i_bit_period);

    assign w_take   = i_rd.valid && (!w_busy || (w_adv && w_rest == '0));
    assign o_rd_pop = w_take;

    always_comb begin
        n_mask = r_mask;
        n_pos  = r_pos;
        if (w_take) begin
            n_mask = i_rd.mask;
            n_pos  = '0;
        end else if (w_adv && w_busy) begin
            n_mask = w_rest;
            n_pos  = w_idx + sfpd_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_pos  <= n_pos;
            if (w_adv) begin
                r_out_valid <= w_busy;
            end
        end
        if (w_adv && w_busy) begin
            r_dur  <= (w_prod[PROD_W-1:sfpd_pkg::DUR_W] != '0) ?
                      sfpd_pkg::DUR_MAX : w_prod[sfpd_pkg::DUR_W-1:0];
            r_last <= (w_idx == LAST_POS);
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_run_duration = r_dur;
    assign o_last_run     = r_last;

    a_stop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> r_mask[sfpd_pkg::FRAME_CELLS-1])
        else $error("frame in progress lost its stop boundary");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (r_pos <= w_idx))
        else $error("run start beyond next boundary");

    a_take_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_busy |-> w_adv && (w_rest == '0))
        else $error("new frame loaded before current one finished");

endmodule
`default_nettype wire
